// ===== hw/rtl/drm_pkg.sv =====
// package for the dirty rectangle merge block: word types, mode codes,
// controller to datapath command and status structs; no dependencies
`default_nettype none

package drm_pkg;

   localparam int MaxRegionsDefault = 16;
   localparam int CoordWidth        = 16;
   localparam int ExtWidth          = 17;
   localparam int CalcWidth         = 20;
   localparam int EntryWidth        = 2 * CoordWidth + 2 * ExtWidth;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_PAGE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic signed [15:0] rect_width;
      logic signed [15:0] rect_height;
   } req_type;

   typedef struct packed {
      logic               whole_page;
      logic [4:0]         region_count;
      logic               entry_valid;
      logic signed [15:0] entry_left;
      logic signed [15:0] entry_top;
      logic [16:0]        entry_width;
      logic [16:0]        entry_height;
      logic               last;
      logic               rect_ignored;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_new;
      logic load;
      logic absorb;
   } cmd_type;

   typedef struct packed {
      logic overlap;
      logic bad_rect;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/drm_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module drm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/drm_dpath.sv =====
// datapath: working rectangle, table ram, overlap test and union
// depends on drm_pkg and drm_ram
`default_nettype none

module drm_dpath #(
   parameter int MaxRegions = drm_pkg::MaxRegionsDefault
) (
   input  wire logic                          clock,
   input  wire drm_pkg::req_type              req_data,
   input  wire drm_pkg::cmd_type              cmd,
   input  wire logic [$clog2(MaxRegions)-1:0] rd_addr,
   input  wire logic [$clog2(MaxRegions)-1:0] wr_addr,
   output drm_pkg::status_type                status,
   output logic [drm_pkg::EntryWidth-1:0]     entry
);
   import drm_pkg::*;

   logic signed [CalcWidth-1:0] l_ff, t_ff, r_ff, b_ff;
   logic signed [CalcWidth-1:0] l_in, t_in, r_in, b_in;
   logic signed [CalcWidth-1:0] el, et, er, eb, nw, nh;
   logic [EntryWidth-1:0]       wr_data;

   drm_ram #(.Width(EntryWidth), .Depth(MaxRegions)) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   always_comb begin
      el = CalcWidth'(signed'(entry[15:0]));
      et = CalcWidth'(signed'(entry[31:16]));
      er = el + signed'(CalcWidth'(entry[48:32]));
      eb = et + signed'(CalcWidth'(entry[65:49]));
      status.overlap  = !(er < l_ff || r_ff < el || eb < t_ff || b_ff < et);
      status.bad_rect = (req_data.rect_width <= 16'sd0) || (req_data.rect_height <= 16'sd0);
      nw = r_ff - l_ff;
      nh = b_ff - t_ff;
      wr_data = cmd.wr_new ? {nh[16:0], nw[16:0], t_ff[15:0], l_ff[15:0]} : entry;
   end

   always_comb begin
      l_in = l_ff;
      t_in = t_ff;
      r_in = r_ff;
      b_in = b_ff;
      if (cmd.load) begin
         l_in = CalcWidth'(req_data.rect_x);
         t_in = CalcWidth'(req_data.rect_y);
         r_in = CalcWidth'(req_data.rect_x) + CalcWidth'(req_data.rect_width);
         b_in = CalcWidth'(req_data.rect_y) + CalcWidth'(req_data.rect_height);
      end else if (cmd.absorb) begin
         if (el < l_ff) l_in = el;
         if (et < t_ff) t_in = et;
         if (er > r_ff) r_in = er;
         if (eb > b_ff) b_in = eb;
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;
      t_ff <= t_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/drm_ctrl.sv =====
// controller: mode decode, merge passes with in-place compaction, read-out
// depends on drm_pkg
`default_nettype none

module drm_ctrl #(
   parameter int MaxRegions = drm_pkg::MaxRegionsDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [1:0]                    mode,
   input  wire drm_pkg::status_type           status,
   output logic                               busy,
   output drm_pkg::cmd_type                   cmd,
   output logic [$clog2(MaxRegions)-1:0]      rd_addr,
   output logic [$clog2(MaxRegions)-1:0]      wr_addr,
   output logic                               rsp_strobe,
   output logic                               whole_page,
   output logic [4:0]                         region_count,
   output logic                               entry_valid,
   output logic                               last,
   output logic                               rect_ignored
);
   import drm_pkg::*;

   localparam int AW = $clog2(MaxRegions);
   localparam int CW = $clog2(MaxRegions + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in, count_ff, count_in;
   logic          pend_ff, pend_in, merged_ff, merged_in, page_ff, page_in;
   logic          strobe_ff, strobe_in, last_ff, last_in, ign_ff, ign_in;
   logic          valid_ff, valid_in;
   logic          issue;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      count_in  = count_ff;
      pend_in   = 1'b0;
      merged_in = merged_ff;
      page_in   = page_ff;
      strobe_in = 1'b0;
      last_in   = 1'b0;
      ign_in    = 1'b0;
      valid_in  = 1'b0;
      cmd       = '0;
      issue     = i_ff < n_ff;
      rd_addr   = i_ff[AW-1:0];
      wr_addr   = j_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in = '0;
               j_in = '0;
               n_in = count_ff;
               merged_in = 1'b0;
               unique case (mode)
                  MODE_ADD: begin
                     if (page_ff || status.bad_rect) begin
                        strobe_in = 1'b1;
                        last_in   = 1'b1;
                        ign_in    = 1'b1;
                     end else begin
                        cmd.load = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_PAGE: begin
                     page_in   = 1'b1;
                     count_in  = '0;
                     strobe_in = 1'b1;
                     last_in   = 1'b1;
                  end
                  MODE_CLEAR: begin
                     page_in   = 1'b0;
                     count_in  = '0;
                     strobe_in = 1'b1;
                     last_in   = 1'b1;
                  end
                  MODE_READ: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        last_in   = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cmd.rd_en = 1'b1;
               i_in      = CW'(i_ff + 1'b1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (status.overlap) begin
                  cmd.absorb = 1'b1;
                  merged_in  = 1'b1;
               end else begin
                  cmd.wr_en = 1'b1;
                  j_in      = CW'(j_ff + 1'b1);
               end
            end else if (!issue) begin
               if (merged_ff) begin
                  n_in      = j_ff;
                  i_in      = '0;
                  j_in      = '0;
                  merged_in = 1'b0;
               end else begin
                  if (j_ff >= CW'(MaxRegions)) begin
                     page_in  = 1'b1;
                     count_in = '0;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_new = 1'b1;
                     count_in   = CW'(j_ff + 1'b1);
                  end
                  strobe_in = 1'b1;
                  last_in   = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            strobe_in = 1'b1;
            valid_in  = 1'b1;
            i_in      = CW'(i_ff + 1'b1);
            if (CW'(i_ff + 1'b1) == n_ff) begin
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         i_ff      <= '0;
         j_ff      <= '0;
         n_ff      <= '0;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         merged_ff <= 1'b0;
         page_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         ign_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         n_ff      <= n_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         merged_ff <= merged_in;
         page_ff   <= page_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
         ign_ff    <= ign_in;
         valid_ff  <= valid_in;
      end
   end

   assign busy         = state_ff != ST_IDLE;
   assign rsp_strobe   = strobe_ff;
   assign whole_page   = page_ff;
   assign region_count = 5'(count_ff);
   assign entry_valid  = valid_ff;
   assign last         = last_ff;
   assign rect_ignored = ign_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dirty_rectangle_merge_top.sv =====
// Dirty rectangle tracker. One word is taken when start is high and busy is
// low; results leave on rsp_data, one per cycle while rsp_strobe is high, and
// must be taken as they appear since there is no back-pressure. Clear, whole
// page and a dropped add answer in the cycle after the start is taken. An add
// runs merge passes over the table through one ram read port, repeated until
// a pass absorbs nothing; the answer comes as busy falls. A read-out gives
// one entry a cycle, each through the registered ram read port after the
// start has moved the state register into read; busy falls as the last
// entry leaves.
// depends on drm_pkg, drm_ctrl, drm_dpath, drm_ram
`default_nettype none

module dirty_rectangle_merge_top #(
   parameter int MaxRegions = drm_pkg::MaxRegionsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire drm_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output drm_pkg::rsp_type      rsp_data
);
   import drm_pkg::*;

   localparam int AW = $clog2(MaxRegions);

   cmd_type               cmd;
   status_type            status;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [EntryWidth-1:0] entry;
   logic                  whole_page, entry_valid, last, rect_ignored;
   logic [4:0]            region_count;

   drm_ctrl #(.MaxRegions(MaxRegions)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .mode         (req_data.mode),
      .status       (status),
      .busy         (busy),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .rsp_strobe   (rsp_strobe),
      .whole_page   (whole_page),
      .region_count (region_count),
      .entry_valid  (entry_valid),
      .last         (last),
      .rect_ignored (rect_ignored)
   );

   drm_dpath #(.MaxRegions(MaxRegions)) u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .status   (status),
      .entry    (entry)
   );

   always_comb begin
      rsp_data.whole_page   = whole_page;
      rsp_data.region_count = region_count;
      rsp_data.entry_valid  = entry_valid;
      rsp_data.entry_left   = entry_valid ? entry[15:0]  : '0;
      rsp_data.entry_top    = entry_valid ? entry[31:16] : '0;
      rsp_data.entry_width  = entry_valid ? entry[48:32] : '0;
      rsp_data.entry_height = entry_valid ? entry[65:49] : '0;
      rsp_data.last         = last;
      rsp_data.rect_ignored = rect_ignored;
   end

endmodule

`default_nettype wire
